// File: rtl/core/fmrn_pkg.sv
// Package with the shared types, widths and constants of the feature normalizer.
`timescale 1ns / 1ps

package fmrn_pkg;

    localparam int DEFAULT_MAX_ROWS     = 64;
    localparam int DEFAULT_SAMPLE_WIDTH = 32;

    localparam int NUM_ROWS_W  = 7;
    localparam int NUM_COLS_W  = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int ROW_INDEX_W = 6;
    localparam int OUT_W       = 32;

    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RESET    = 7'd64;
    localparam logic [NUM_COLS_W-1:0] NUM_COLUMNS_RESET = 8'd1;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLUMNS = 1'b1;

    localparam int FRAC_BITS   = 30;
    localparam int QUO_W       = FRAC_BITS + 1;
    localparam int FRAC_STEPS  = 2;
    localparam int FRAC_CYCLES = FRAC_BITS / FRAC_STEPS;

    typedef enum logic [3:0] {
        S_LOAD,
        S_MEAN_INIT,
        S_MEAN,
        S_MEAN_END,
        S_READ,
        S_DIFF,
        S_ABS,
        S_QINT,
        S_QFRAC,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mean_init;
        logic mean_step;
        logic mean_end;
        logic rd;
        logic diff;
        logic absval;
        logic qint;
        logic qfrac;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic col_done;
        logic step_last;
        logic last_row;
    } status_t;

endpackage

// File: rtl/core/fmrn_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module fmrn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/fmrn_datapath.sv
// Datapath: sample store, running statistics, mean and quotient dividers, result registers.
`timescale 1ns / 1ps

module fmrn_datapath #(
    parameter int MAX_ROWS     = fmrn_pkg::DEFAULT_MAX_ROWS,
    parameter int SAMPLE_WIDTH = fmrn_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fmrn_pkg::cmd_t                     cmd,
    output fmrn_pkg::status_t                  status,
    input  logic                               cfg_write,
    input  logic [fmrn_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fmrn_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [SAMPLE_WIDTH-1:0]            sample,
    output logic                               result_valid,
    output logic [fmrn_pkg::OUT_W-1:0]         normalized,
    output logic [fmrn_pkg::NUM_COLS_W-1:0]    column_index,
    output logic [fmrn_pkg::ROW_INDEX_W-1:0]   row_index,
    output logic                               range_zero,
    output logic                               last
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CW    = RIW + 1;
    localparam int SUM_W = SW + RIW;
    localparam int REMW  = SW + 2;
    localparam int SCW   = $clog2(SUM_W + 1);
    localparam int QW    = fmrn_pkg::QUO_W;
    localparam int NRW   = fmrn_pkg::NUM_ROWS_W;
    localparam int NCW   = fmrn_pkg::NUM_COLS_W;
    localparam int OW    = fmrn_pkg::OUT_W;

    // Control state.
    logic [NRW-1:0] num_rows_reg;
    logic [NCW-1:0] num_columns_reg;
    logic [RIW-1:0] row_count_reg;
    logic [NCW-1:0] column_count_reg;
    logic [RIW-1:0] row_idx_reg;
    logic [SCW-1:0] step_cnt_reg;
    logic           result_valid_reg;

    // Payload state.
    logic signed [SW-1:0]    max_reg;
    logic signed [SW-1:0]    min_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           mrem_reg;
    logic [SUM_W-1:0]        mquo_reg;
    logic                    mneg_reg;
    logic signed [SW-1:0]    mean_reg;
    logic [SW-1:0]           range_reg;
    logic                    zero_reg;
    logic signed [SW:0]      diff_reg;
    logic                    neg_reg;
    logic [REMW-1:0]         rem_reg;
    logic [QW-1:0]           quo_reg;
    logic                    sat_reg;
    logic [OW-1:0]           normalized_reg;
    logic [NCW-1:0]          column_index_reg;
    logic [fmrn_pkg::ROW_INDEX_W-1:0] row_index_reg;
    logic                    range_zero_reg;
    logic                    last_reg;

    logic [SW-1:0]        rd_data;
    logic [CW-1:0]        n_eff;
    logic [CW-1:0]        count;
    logic [NCW-1:0]       cols_eff;
    logic [NCW:0]         col_plus;
    logic [NCW-1:0]       column_next;
    logic [CW:0]          mshift;
    logic                 mge;
    logic [CW-1:0]        mrem_next;
    logic [SUM_W-1:0]     mean_mag;
    logic [SUM_W-1:0]     mean_full;
    logic [SW:0]          range_wide;
    logic [REMW-1:0]      diff_ext;
    logic [REMW-1:0]      range_x;
    logic [REMW-1:0]      range_x2;
    logic                 ge1;
    logic                 ge2;
    logic [REMW-1:0]      rem_frac;
    logic [QW-1:0]        quo_frac;
    logic [QW-1:0]        quo_clamped;
    logic [OW-1:0]        quo_out;
    logic [OW-1:0]        normalized_next;

    fmrn_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_ROWS)
    ) u_store (
        .clk  (clk),
        .we   (cmd.load),
        .waddr(row_count_reg),
        .wdata(sample),
        .re   (cmd.rd),
        .raddr(row_idx_reg),
        .rdata(rd_data)
    );

    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (num_rows_reg > NRW'(MAX_ROWS))
        begin
            n_eff = CW'(MAX_ROWS);
        end
        else
        begin
            n_eff = CW'(num_rows_reg);
        end
    end

    assign count       = CW'(row_count_reg) + CW'(1);
    assign cols_eff    = (num_columns_reg == '0) ? NCW'(1) : num_columns_reg;
    assign col_plus    = {1'b0, column_count_reg} + (NCW + 1)'(1);
    assign column_next = (col_plus >= {1'b0, cols_eff}) ? '0 : col_plus[NCW-1:0];

    assign status.col_done  = (count >= n_eff);
    assign status.step_last = (step_cnt_reg == SCW'(1));
    assign status.last_row  = ((CW'(row_idx_reg) + CW'(1)) == count_reg);

    // Mean divider: one restoring step per cycle.
    assign mshift    = {mrem_reg, mquo_reg[SUM_W-1]};
    assign mge       = (mshift >= {1'b0, count_reg});
    assign mrem_next = mge ? CW'(mshift - {1'b0, count_reg}) : mshift[CW-1:0];
    assign mean_mag  = mquo_reg;
    assign mean_full = mneg_reg ? (SUM_W'(0) - mean_mag) : mean_mag;

    assign range_wide = {max_reg[SW-1], max_reg} - {min_reg[SW-1], min_reg};
    assign diff_ext   = REMW'(diff_reg);
    assign range_x    = REMW'(range_reg);
    assign range_x2   = {1'b0, range_reg, 1'b0};
    assign ge1        = (rem_reg >= range_x);
    assign ge2        = (rem_reg >= range_x2);

    // Fraction bits of the quotient, two per cycle.
    always_comb
    begin
        logic [REMW-1:0] r;
        logic [QW-1:0]   q;
        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < fmrn_pkg::FRAC_STEPS; k++)
        begin
            r = {r[REMW-2:0], 1'b0};
            if (r >= range_x)
            begin
                r = r - range_x;
                q = {q[QW-2:0], 1'b1};
            end
            else
            begin
                q = {q[QW-2:0], 1'b0};
            end
        end
        rem_frac = r;
        quo_frac = q;
    end

    always_comb
    begin
        logic [QW-1:0] qmax;
        qmax = QW'(1) << fmrn_pkg::FRAC_BITS;
        if (sat_reg || (quo_reg > qmax))
        begin
            quo_clamped = qmax;
        end
        else
        begin
            quo_clamped = quo_reg;
        end
        quo_out = OW'(quo_clamped);
        if (zero_reg)
        begin
            normalized_next = '0;
        end
        else if (neg_reg)
        begin
            normalized_next = OW'(0) - quo_out;
        end
        else
        begin
            normalized_next = quo_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg     <= fmrn_pkg::NUM_ROWS_RESET;
            num_columns_reg  <= fmrn_pkg::NUM_COLUMNS_RESET;
            row_count_reg    <= '0;
            column_count_reg <= '0;
            row_idx_reg      <= '0;
            step_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
            if (cfg_write)
            begin
                case (cfg_index)
                    fmrn_pkg::REG_NUM_ROWS:
                    begin
                        num_rows_reg <= cfg_data[NRW-1:0];
                    end
                    fmrn_pkg::REG_NUM_COLUMNS:
                    begin
                        num_columns_reg <= cfg_data[NCW-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load)
            begin
                row_count_reg <= status.col_done ? '0 : count[RIW-1:0];
            end
            if (cmd.mean_init)
            begin
                step_cnt_reg <= SCW'(SUM_W);
            end
            else if (cmd.qint)
            begin
                step_cnt_reg <= SCW'(fmrn_pkg::FRAC_CYCLES);
            end
            else if (cmd.mean_step || cmd.qfrac)
            begin
                step_cnt_reg <= step_cnt_reg - SCW'(1);
            end
            if (cmd.mean_end)
            begin
                row_idx_reg <= '0;
            end
            else if (cmd.emit)
            begin
                row_idx_reg <= row_idx_reg + RIW'(1);
                if (status.last_row)
                begin
                    column_count_reg <= column_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (row_count_reg == '0)
            begin
                max_reg <= $signed(sample);
                min_reg <= $signed(sample);
                sum_reg <= SUM_W'($signed(sample));
            end
            else
            begin
                if ($signed(sample) > max_reg)
                begin
                    max_reg <= $signed(sample);
                end
                if ($signed(sample) < min_reg)
                begin
                    min_reg <= $signed(sample);
                end
                sum_reg <= sum_reg + SUM_W'($signed(sample));
            end
            count_reg <= count;
        end
        if (cmd.mean_init)
        begin
            mrem_reg <= '0;
            mneg_reg <= sum_reg[SUM_W-1];
            mquo_reg <= sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;
        end
        if (cmd.mean_step)
        begin
            mrem_reg <= mrem_next;
            mquo_reg <= {mquo_reg[SUM_W-2:0], mge};
        end
        if (cmd.mean_end)
        begin
            mean_reg  <= mean_full[SW-1:0];
            range_reg <= range_wide[SW-1:0];
            zero_reg  <= (max_reg == min_reg);
        end
        if (cmd.diff)
        begin
            diff_reg <= {rd_data[SW-1], rd_data} - {mean_reg[SW-1], mean_reg};
        end
        if (cmd.absval)
        begin
            neg_reg <= diff_reg[SW];
            rem_reg <= diff_reg[SW] ? (REMW'(0) - diff_ext) : diff_ext;
        end
        if (cmd.qint)
        begin
            quo_reg <= QW'(ge1);
            sat_reg <= ge2;
            rem_reg <= ge1 ? (rem_reg - range_x) : rem_reg;
        end
        if (cmd.qfrac)
        begin
            rem_reg <= rem_frac;
            quo_reg <= quo_frac;
        end
        if (cmd.emit)
        begin
            normalized_reg   <= normalized_next;
            column_index_reg <= column_count_reg;
            row_index_reg    <= fmrn_pkg::ROW_INDEX_W'(row_idx_reg);
            range_zero_reg   <= zero_reg;
            last_reg         <= status.last_row;
        end
    end

    assign result_valid = result_valid_reg;
    assign normalized   = normalized_reg;
    assign column_index = column_index_reg;
    assign row_index    = row_index_reg;
    assign range_zero   = range_zero_reg;
    assign last         = last_reg;

endmodule

// File: rtl/core/fmrn_ctrl.sv
// Controller state machine that sequences loading, the mean division and each result.
`timescale 1ns / 1ps

module fmrn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  fmrn_pkg::status_t status,
    output fmrn_pkg::cmd_t    cmd,
    output logic              busy
);

    fmrn_pkg::state_t state_reg;
    fmrn_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmrn_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            fmrn_pkg::S_LOAD:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (status.col_done)
                    begin
                        state_next = fmrn_pkg::S_MEAN_INIT;
                    end
                end
            end
            fmrn_pkg::S_MEAN_INIT:
            begin
                cmd.mean_init = 1'b1;
                state_next    = fmrn_pkg::S_MEAN;
            end
            fmrn_pkg::S_MEAN:
            begin
                cmd.mean_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = fmrn_pkg::S_MEAN_END;
                end
            end
            fmrn_pkg::S_MEAN_END:
            begin
                cmd.mean_end = 1'b1;
                state_next   = fmrn_pkg::S_READ;
            end
            fmrn_pkg::S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = fmrn_pkg::S_DIFF;
            end
            fmrn_pkg::S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = fmrn_pkg::S_ABS;
            end
            fmrn_pkg::S_ABS:
            begin
                cmd.absval = 1'b1;
                state_next = fmrn_pkg::S_QINT;
            end
            fmrn_pkg::S_QINT:
            begin
                cmd.qint   = 1'b1;
                state_next = fmrn_pkg::S_QFRAC;
            end
            fmrn_pkg::S_QFRAC:
            begin
                cmd.qfrac = 1'b1;
                if (status.step_last)
                begin
                    state_next = fmrn_pkg::S_EMIT;
                end
            end
            fmrn_pkg::S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = status.last_row ? fmrn_pkg::S_LOAD : fmrn_pkg::S_READ;
            end
            default:
            begin
                state_next = fmrn_pkg::S_LOAD;
            end
        endcase
    end

endmodule

// File: rtl/core/feature_mean_range_normalizer_core.sv
// Top level of the mean-normalization feature scaler.
`timescale 1ns / 1ps

// Samples enter column by column as requests: a request is taken at a clock edge where
// start is high and busy is low. Each column holds num_rows samples (register 0, clamped
// to 1..MAX_ROWS); loading takes one sample per cycle with busy low.
// The sample that completes a column raises busy. The block then divides the column sum
// by the sample count, one quotient bit per cycle, and then produces one result per stored
// row in row order. Each result passes through the store read, the subtraction of the mean,
// the magnitude and the integer bit, then the fractional divider, which resolves two
// quotient bits per cycle over 30 fraction bits. A result is shown for exactly one cycle
// with result_valid high; the receiver cannot stall. busy falls in the cycle the last
// result of a column appears, and the next column's first sample may be taken in that
// same cycle. The column index wraps after num_columns (register 1). The user must write
// configuration through cfg_write, cfg_index and cfg_data only while the block is idle;
// the block itself does not enforce this. Reset clears the row and column counts and
// restores the registers to 64 rows and 1 column; the sample store needs no clearing.

module feature_mean_range_normalizer_core #(
    parameter int MAX_ROWS     = fmrn_pkg::DEFAULT_MAX_ROWS,
    parameter int SAMPLE_WIDTH = fmrn_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [fmrn_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fmrn_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [SAMPLE_WIDTH-1:0]           sample,
    output logic                              result_valid,
    output logic [fmrn_pkg::OUT_W-1:0]        normalized,
    output logic [fmrn_pkg::NUM_COLS_W-1:0]   column_index,
    output logic [fmrn_pkg::ROW_INDEX_W-1:0]  row_index,
    output logic                              range_zero,
    output logic                              last
);

    fmrn_pkg::cmd_t    cmd;
    fmrn_pkg::status_t status;

    fmrn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .cmd   (cmd),
        .busy  (busy)
    );

    fmrn_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .result_valid(result_valid),
        .normalized  (normalized),
        .column_index(column_index),
        .row_index   (row_index),
        .range_zero  (range_zero),
        .last        (last)
    );

endmodule

// File: rtl/core/fmrn_checker.sv
// Port-level checker for the feature normalizer, bound to the top level.
`timescale 1ns / 1ps

module fmrn_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       result_valid,
    input logic                       range_zero,
    input logic                       last,
    input logic [fmrn_pkg::OUT_W-1:0] normalized
);

    // Every result passes through the division, so strobes never come back to back.
    a_strobe_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results strobed in consecutive cycles");

    // A loading request cannot be followed at once by a result.
    a_no_result_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
        else $error("result right after a loading request");

    // Until the last result of a column is out, no new request is taken.
    a_busy_mid_column: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("block idle in the middle of a column's results");

    a_zero_range_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && range_zero) |-> (normalized == '0))
        else $error("nonzero result for a zero-range column");

    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($signed(normalized) <= 32'sd1073741824
                          && $signed(normalized) >= -32'sd1073741824))
        else $error("result outside the Q1.30 range");

endmodule

bind feature_mean_range_normalizer_core fmrn_checker u_fmrn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .result_valid(result_valid),
    .range_zero  (range_zero),
    .last        (last),
    .normalized  (normalized)
);
